### src/routing_table_lpm_lookup_core_assert.svh
// Assertion macros for the routing table lookup core.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ROUTING_TABLE_LPM_LOOKUP_CORE_ASSERT_SVH
`define ROUTING_TABLE_LPM_LOOKUP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define RTLPM_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rtlpm assertion failed");

`define RTLPM_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rtlpm assertion failed");

`else

`define RTLPM_ASSERT_IMP(name, ck, rs, ante, cons)

`define RTLPM_ASSERT_NXT(name, ck, rs, ante, cons)

`endif

`endif

### src/rtlpm_pkg.sv
// Shared types, codes and helpers for the routing table lookup core.
// No dependencies.
package rtlpm_pkg;

  localparam int IP_W    = 32;
  localparam int IFACE_W = 4;
  localparam int ENTRY_W = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_FOUND = 2'd2,
    STAT_NONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } fsm_t;

  typedef struct packed {
    logic [IP_W-1:0]    dest_m;
    logic [IP_W-1:0]    mask;
    logic [IP_W-1:0]    gateway;
    logic [IFACE_W-1:0] iface;
  } route_entry_t;

  typedef struct packed {
    logic            start;
    logic            step;
    logic [IP_W-1:0] addr;
  } walk_ctl_t;

  typedef struct packed {
    logic               found;
    logic [IP_W-1:0]    gateway;
    logic [IFACE_W-1:0] iface;
  } walk_res_t;

  // interface index modulo the interface count, by repeated subtraction
  function automatic logic [IFACE_W-1:0] iface_wrap(logic [IFACE_W-1:0] v,
                                                    int unsigned n);
    logic [IFACE_W-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= n) begin
        r = r - IFACE_W'(n);
      end
    end
    return r;
  endfunction

endpackage

### src/rtlpm_if.sv
// Request and result channel interfaces of the routing table lookup core.
// Depends on rtlpm_pkg.
interface rtlpm_req_if import rtlpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [IP_W-1:0]    net_addr;
  logic [IP_W-1:0]    gateway_addr;
  logic [IP_W-1:0]    prefix_mask;
  logic [IFACE_W-1:0] iface_index;
  logic [IP_W-1:0]    lookup_addr;

  modport source (output valid, op, net_addr, gateway_addr, prefix_mask,
                  iface_index, lookup_addr, input ready);
  modport sink (input valid, op, net_addr, gateway_addr, prefix_mask,
                iface_index, lookup_addr, output ready);
endinterface

interface rtlpm_rsp_if import rtlpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [IP_W-1:0]    out_gateway;
  logic [IFACE_W-1:0] out_iface;
  logic [ENTRY_W-1:0] out_entry;

  modport source (output valid, status, out_gateway, out_iface, out_entry,
                  input ready);
  modport sink (input valid, status, out_gateway, out_iface, out_entry,
                output ready);
endinterface

### src/routing_table_lpm_lookup_core.sv
// Routing table with longest-prefix-match lookup, top level.
// Add, clear and unused op: the result is registered, then moved to the output
// registers in S_EMIT. Lookup reads one entry per cycle from the route memory,
// none on an empty table; the next request is taken with the result.
// Reset (rst, synchronous) empties the table; memory contents are not cleared.
// Depends on rtlpm_pkg, rtlpm_if, rtlpm_route_mem, rtlpm_walker.
`include "routing_table_lpm_lookup_core_assert.svh"

module routing_table_lpm_lookup_core import rtlpm_pkg::*; #(
  parameter int TABLE_DEPTH = 32,
  parameter int IFACE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  rtlpm_req_if.sink   request,
  rtlpm_rsp_if.source response
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  fsm_t             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] issue_idx, issue_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;

  status_t            res_status, res_status_c;
  logic [IP_W-1:0]    res_gw, res_gw_c;
  logic [IFACE_W-1:0] res_if, res_if_c;
  logic [ENTRY_W-1:0] res_entry, res_entry_c;
  logic               res_load;

  logic               out_valid;
  logic               out_load;
  status_t            out_status;
  logic [IP_W-1:0]    out_gw;
  logic [IFACE_W-1:0] out_if;
  logic [ENTRY_W-1:0] out_ent;

  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  route_entry_t     mem_wdata;
  route_entry_t     mem_rdata;

  walk_ctl_t        walk_ctl;
  walk_res_t        walk_res;
  logic [IDX_W-1:0] walk_idx;

  logic req_take;

  assign request.ready = (state == S_IDLE);
  assign req_take      = request.valid && request.ready;

  assign mem_wdata.dest_m  = request.net_addr & request.prefix_mask;
  assign mem_wdata.mask    = request.prefix_mask;
  assign mem_wdata.gateway = request.gateway_addr;
  assign mem_wdata.iface   = iface_wrap(request.iface_index, IFACE_COUNT);

  rtlpm_route_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rtlpm_walker #(
    .IDX_W (IDX_W)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .ctl     (walk_ctl),
    .entry   (mem_rdata),
    .idx     (pend_idx),
    .res     (walk_res),
    .res_idx (walk_idx)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    issue_next     = issue_idx;
    pend_next      = 1'b0;
    pend_idx_next  = pend_idx;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = issue_idx[IDX_W-1:0];
    res_load       = 1'b0;
    res_status_c   = STAT_NONE;
    res_gw_c       = '0;
    res_if_c       = '0;
    res_entry_c    = '0;
    out_load       = 1'b0;
    walk_ctl.start = 1'b0;
    walk_ctl.step  = 1'b0;
    walk_ctl.addr  = request.lookup_addr;

    case (state)
      S_IDLE: begin
        if (request.valid) begin
          case (request.op)
            OP_ADD: begin
              res_load   = 1'b1;
              state_next = S_EMIT;
              if (count == DEPTH_C) begin
                res_status_c = STAT_FULL;
              end else begin
                mem_we       = 1'b1;
                count_next   = count + 1'b1;
                res_status_c = STAT_OK;
                res_entry_c  = ENTRY_W'(count);
              end
            end
            OP_LOOKUP: begin
              if (count == '0) begin
                res_load   = 1'b1;
                state_next = S_EMIT;
              end else begin
                mem_re         = 1'b1;
                mem_raddr      = '0;
                issue_next     = CNT_W'(1);
                pend_next      = 1'b1;
                pend_idx_next  = '0;
                walk_ctl.start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_next   = '0;
              res_status_c = STAT_OK;
              res_load     = 1'b1;
              state_next   = S_EMIT;
            end
            default: begin
              res_load   = 1'b1;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        walk_ctl.step = pend;
        if (issue_idx < count) begin
          mem_re        = 1'b1;
          issue_next    = issue_idx + 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = issue_idx[IDX_W-1:0];
        end else if (!pend) begin
          res_load   = 1'b1;
          state_next = S_EMIT;
          if (walk_res.found) begin
            res_status_c = STAT_FOUND;
            res_gw_c     = walk_res.gateway;
            res_if_c     = walk_res.iface;
            res_entry_c  = ENTRY_W'(walk_idx);
          end
        end
      end
      S_EMIT: begin
        if (!out_valid || response.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issue_idx <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      issue_idx <= issue_next;
      pend      <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    if (res_load) begin
      res_status <= res_status_c;
      res_gw     <= res_gw_c;
      res_if     <= res_if_c;
      res_entry  <= res_entry_c;
    end
    if (out_load) begin
      out_status <= res_status;
      out_gw     <= res_gw;
      out_if     <= res_if;
      out_ent    <= res_entry;
    end
  end

  assign response.valid       = out_valid;
  assign response.status      = out_status;
  assign response.out_gateway = out_gw;
  assign response.out_iface   = out_if;
  assign response.out_entry   = out_ent;

  `RTLPM_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= DEPTH_C)
  `RTLPM_ASSERT_IMP(a_issue_bound, clk, rst, state == S_SCAN, issue_idx <= count)
  `RTLPM_ASSERT_IMP(a_pend_scan, clk, rst, pend, state == S_SCAN)
  `RTLPM_ASSERT_NXT(a_add_count, clk, rst,
                    req_take && (request.op == OP_ADD) && (count != DEPTH_C),
                    count == $past(count) + 1'b1)

endmodule

### src/rtlpm_route_mem.sv
// Route table storage: one write port, one registered read port.
// Depends on rtlpm_pkg for the entry layout.
module rtlpm_route_mem import rtlpm_pkg::*; #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  route_entry_t      wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output route_entry_t      rdata
);

  route_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/rtlpm_walker.sv
// Longest-prefix selection over the entry stream read from the table.
// Depends on rtlpm_pkg.
module rtlpm_walker import rtlpm_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  walk_ctl_t        ctl,
  input  route_entry_t     entry,
  input  logic [IDX_W-1:0] idx,
  output walk_res_t        res,
  output logic [IDX_W-1:0] res_idx
);

  logic [IP_W-1:0]    addr_q;
  logic               have_best;
  logic [IP_W-1:0]    best_mask;
  logic [IP_W-1:0]    best_gw;
  logic [IFACE_W-1:0] best_if;
  logic [IDX_W-1:0]   best_idx;
  logic               have_dflt;
  logic [IP_W-1:0]    dflt_gw;
  logic [IFACE_W-1:0] dflt_if;
  logic [IDX_W-1:0]   dflt_idx;

  logic hit;
  logic take_best;
  logic take_dflt;

  always_comb begin
    hit       = (addr_q & entry.mask) == entry.dest_m;
    take_dflt = ctl.step && hit && (entry.dest_m == '0);
    take_best = ctl.step && hit && (entry.dest_m != '0) &&
                (!have_best || (entry.mask > best_mask));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      have_dflt <= 1'b0;
    end else if (ctl.start) begin
      have_best <= 1'b0;
      have_dflt <= 1'b0;
    end else begin
      if (take_best) begin
        have_best <= 1'b1;
      end
      if (take_dflt) begin
        have_dflt <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      addr_q <= ctl.addr;
    end
    if (take_best) begin
      best_mask <= entry.mask;
      best_gw   <= entry.gateway;
      best_if   <= entry.iface;
      best_idx  <= idx;
    end
    if (take_dflt) begin
      dflt_gw  <= entry.gateway;
      dflt_if  <= entry.iface;
      dflt_idx <= idx;
    end
  end

  always_comb begin
    res.found   = have_best || have_dflt;
    res.gateway = have_best ? best_gw : dflt_gw;
    res.iface   = have_best ? best_if : dflt_if;
    res_idx     = have_best ? best_idx : dflt_idx;
  end

endmodule
